// ===== rtl/rgb2hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Shared types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int CH_W  = 18;   // input channel width, two's complement
   localparam int HUE_W = 16;
   localparam int SV_W  = 17;
   localparam int THR_W = 16;

   localparam logic [THR_W-1:0] THR_RESET = 16'd6;

   // per-pixel control that travels alongside the datapath
   typedef struct packed {
      logic valid;
      logic gray;
   } ctrl_type;

endpackage

// ===== rtl/rgb2hsv_front.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_front
// Four-stage front end: channel clamp, max/min and sector pick, chroma span
// and gray test, then hue numerator and denominator for the dividers.
// ----------------------------------------------------------------------------
module rgb2hsv_front
   import rgb2hsv_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [CH_W-1:0]         red,
   input  logic [CH_W-1:0]         green,
   input  logic [CH_W-1:0]         blue,
   input  logic [THR_W-1:0]        threshold,
   output ctrl_type                out_ctrl,
   output logic [FRAC_BITS:0]      out_value,
   output logic [FRAC_BITS:0]      out_delta,
   output logic [FRAC_BITS+2:0]    out_num,
   output logic [FRAC_BITS+2:0]    out_den
);

   localparam int VW = FRAC_BITS + 1;
   localparam int HW = VW + 2;
   localparam int CW = (VW > CH_W - 1) ? VW : CH_W - 1;
   localparam int TW = (VW > THR_W) ? VW : THR_W;
   localparam logic [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

   localparam logic [1:0] SEC_RED   = 2'd0;
   localparam logic [1:0] SEC_GREEN = 2'd1;
   localparam logic [1:0] SEC_BLUE  = 2'd2;

   function automatic logic [VW-1:0] clamp(input logic [CH_W-1:0] x);
      logic [CW-1:0] mag;
      logic [CW-1:0] res;
      mag = CW'(x[CH_W-2:0]);
      if (x[CH_W-1]) begin
         res = '0;
      end else if (mag > ONE) begin
         res = ONE;
      end else begin
         res = mag;
      end
      return res[VW-1:0];
   endfunction

   // stage 0: clamp
   logic          v0_ff;
   logic [VW-1:0] r0_ff, g0_ff, b0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         r0_ff <= clamp(red);
         g0_ff <= clamp(green);
         b0_ff <= clamp(blue);
      end
   end

   // stage 1: max, min, sector
   logic          v1_ff;
   logic [VW-1:0] r1_ff, g1_ff, b1_ff, mx1_ff, mn1_ff;
   logic [1:0]    sec1_ff;
   logic [VW-1:0] mx1_in, mn1_in;
   logic [1:0]    sec1_in;

   always_comb begin
      mx1_in = r0_ff;
      mn1_in = r0_ff;
      if (g0_ff > mx1_in) mx1_in = g0_ff;
      if (b0_ff > mx1_in) mx1_in = b0_ff;
      if (g0_ff < mn1_in) mn1_in = g0_ff;
      if (b0_ff < mn1_in) mn1_in = b0_ff;
      // red wins ties, then green
      if (r0_ff >= g0_ff && r0_ff >= b0_ff) begin
         sec1_in = SEC_RED;
      end else if (g0_ff >= b0_ff) begin
         sec1_in = SEC_GREEN;
      end else begin
         sec1_in = SEC_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
      if (en) begin
         r1_ff   <= r0_ff;
         g1_ff   <= g0_ff;
         b1_ff   <= b0_ff;
         mx1_ff  <= mx1_in;
         mn1_ff  <= mn1_in;
         sec1_ff <= sec1_in;
      end
   end

   // stage 2: chroma span, signed channel difference, gray test
   logic          v2_ff, gray2_ff;
   logic [VW-1:0] mx2_ff, delta2_ff;
   logic [VW:0]   diff2_ff;
   logic [1:0]    sec2_ff;
   logic [VW:0]   diff2_in;
   logic [VW-1:0] delta2_in;
   logic          gray2_in;

   always_comb begin
      delta2_in = mx1_ff - mn1_ff;
      gray2_in  = TW'(delta2_in) <= TW'(threshold);
      case (sec1_ff)
         SEC_RED:   diff2_in = {1'b0, g1_ff} - {1'b0, b1_ff};
         SEC_GREEN: diff2_in = {1'b0, b1_ff} - {1'b0, r1_ff};
         default:   diff2_in = {1'b0, r1_ff} - {1'b0, g1_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         gray2_ff  <= gray2_in;
         mx2_ff    <= mx1_ff;
         delta2_ff <= delta2_in;
         diff2_ff  <= diff2_in;
         sec2_ff   <= sec1_ff;
      end
   end

   // stage 3: hue numerator and denominator (six times delta)
   ctrl_type      ctrl3_ff;
   logic [VW-1:0] mx3_ff, delta3_ff;
   logic [HW-1:0] num3_ff, den3_ff;
   logic [HW-1:0] d_ext, diff_ext, den3_in, num3_in;

   always_comb begin
      d_ext    = HW'(delta2_ff);
      diff_ext = {diff2_ff[VW], diff2_ff};
      den3_in  = (d_ext << 2) + (d_ext << 1);
      case (sec2_ff)
         SEC_RED:   num3_in = diff2_ff[VW] ? diff_ext + den3_in : diff_ext;
         SEC_GREEN: num3_in = (d_ext << 1) + diff_ext;
         default:   num3_in = (d_ext << 2) + diff_ext;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl3_ff <= '0;
      end else if (en) begin
         ctrl3_ff.valid <= v2_ff;
         ctrl3_ff.gray  <= gray2_ff;
      end
      if (en) begin
         mx3_ff    <= mx2_ff;
         delta3_ff <= delta2_ff;
         num3_ff   <= num3_in;
         den3_ff   <= den3_in;
      end
   end

   assign out_ctrl  = ctrl3_ff;
   assign out_value = mx3_ff;
   assign out_delta = delta3_ff;
   assign out_num   = num3_ff;
   assign out_den   = den3_ff;

endmodule

// ===== rtl/rgb2hsv_div.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_div
// Pipelined restoring divider for a fraction num/den with num <= den.
// One quotient bit per stage: the integer bit first, then fraction bits.
// ----------------------------------------------------------------------------
module rgb2hsv_div
   import rgb2hsv_pkg::*;
#(
   parameter int W     = 17,
   parameter int STEPS = 17
) (
   input  logic             clock,
   input  logic             en,
   input  logic [W-1:0]     num,
   input  logic [W-1:0]     den,
   output logic [STEPS-1:0] quo
);

   logic [W-1:0]     rem_ff [STEPS];
   logic [W-1:0]     den_ff [STEPS];
   logic [STEPS-1:0] quo_ff [STEPS];

   logic             bit0;
   assign bit0 = num >= den;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= bit0 ? num - den : num;
         den_ff[0] <= den;
         quo_ff[0] <= STEPS'(bit0);
      end
   end

   for (genvar k = 1; k < STEPS; k++) begin : g_step
      logic [W:0]   r2;
      logic         q_bit;
      logic [W:0]   r_next;

      always_comb begin
         r2     = {rem_ff[k-1], 1'b0};
         q_bit  = r2 >= {1'b0, den_ff[k-1]};
         r_next = q_bit ? r2 - {1'b0, den_ff[k-1]} : r2;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= r_next[W-1:0];   // remainder stays below den
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= {quo_ff[k-1][STEPS-2:0], q_bit};
         end
      end
   end

   assign quo = quo_ff[STEPS-1];

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// Throughput: one pixel per cycle while req_stall is low;
// the two dividers retire one quotient bit per stage.
// Output register plus one skid entry: the input stalls only once both are full.
// Reset (synchronous, active high) empties the pipeline and sets gray_threshold to 6.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Fixed-point RGB to HSV conversion: clamp front end, saturation and hue
// dividers in parallel, output register with skid buffer.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
   import rgb2hsv_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [THR_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CH_W-1:0]   req_red_in,
   input  logic [CH_W-1:0]   req_green_in,
   input  logic [CH_W-1:0]   req_blue_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HUE_W-1:0]  rsp_hue_out,
   output logic [SV_W-1:0]   rsp_saturation_out,
   output logic [SV_W-1:0]   rsp_value_out
);

   localparam int VW    = FRAC_BITS + 1;
   localparam int HW    = VW + 2;
   localparam int STEPS = FRAC_BITS + 1;

   logic [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   logic skid_valid_ff;
   logic en;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   ctrl_type      f_ctrl;
   logic [VW-1:0] f_value, f_delta;
   logic [HW-1:0] f_num, f_den;

   rgb2hsv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .threshold (thr_ff),
      .out_ctrl  (f_ctrl),
      .out_value (f_value),
      .out_delta (f_delta),
      .out_num   (f_num),
      .out_den   (f_den)
   );

   logic [STEPS-1:0] sat_q, hue_q;

   rgb2hsv_div #(.W(VW), .STEPS(STEPS)) u_sat_div (
      .clock (clock),
      .en    (en),
      .num   (f_delta),
      .den   (f_value),
      .quo   (sat_q)
   );

   rgb2hsv_div #(.W(HW), .STEPS(STEPS)) u_hue_div (
      .clock (clock),
      .en    (en),
      .num   (f_num),
      .den   (f_den),
      .quo   (hue_q)
   );

   // control and value ride alongside the divider stages
   ctrl_type      side_ctrl_ff [STEPS];
   logic [VW-1:0] side_val_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_side
      ctrl_type      ctrl_src;
      logic [VW-1:0] val_src;
      if (k == 0) begin : g_first
         assign ctrl_src = f_ctrl;
         assign val_src  = f_value;
      end else begin : g_next
         assign ctrl_src = side_ctrl_ff[k-1];
         assign val_src  = side_val_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ctrl_ff[k] <= '0;
         end else if (en) begin
            side_ctrl_ff[k] <= ctrl_src;
         end
         if (en) begin
            side_val_ff[k] <= val_src;
         end
      end
   end

   // result formatting, masked to field widths; hue and saturation are zero for gray pixels
   ctrl_type             last_ctrl;
   logic [STEPS+HUE_W-1:0] hue_ext;
   logic [STEPS+SV_W-1:0]  sat_ext;
   logic [VW+SV_W-1:0]     val_ext;
   logic [HUE_W-1:0]     hue_w;
   logic [SV_W-1:0]      sat_w, val_w;

   assign last_ctrl = side_ctrl_ff[STEPS-1];
   assign hue_ext   = {{HUE_W{1'b0}}, hue_q};
   assign sat_ext   = {{SV_W{1'b0}}, sat_q};
   assign val_ext   = {{SV_W{1'b0}}, side_val_ff[STEPS-1]};
   assign hue_w     = last_ctrl.gray ? '0 : hue_ext[HUE_W-1:0];
   assign sat_w     = last_ctrl.gray ? '0 : sat_ext[SV_W-1:0];
   assign val_w     = val_ext[SV_W-1:0];

   // output register and skid entry
   logic             rsp_valid_ff;
   logic [HUE_W-1:0] rsp_hue_ff, skid_hue_ff;
   logic [SV_W-1:0]  rsp_sat_ff, skid_sat_ff;
   logic [SV_W-1:0]  rsp_val_ff, skid_val_ff;
   logic             out_ready, incoming;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign incoming  = en && last_ctrl.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff  <= skid_valid_ff || incoming;
         skid_valid_ff <= 1'b0;
      end else if (incoming) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         if (skid_valid_ff) begin
            rsp_hue_ff <= skid_hue_ff;
            rsp_sat_ff <= skid_sat_ff;
            rsp_val_ff <= skid_val_ff;
         end else begin
            rsp_hue_ff <= hue_w;
            rsp_sat_ff <= sat_w;
            rsp_val_ff <= val_w;
         end
      end else if (incoming) begin
         skid_hue_ff <= hue_w;
         skid_sat_ff <= sat_w;
         skid_val_ff <= val_w;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hue_out        = rsp_hue_ff;
   assign rsp_saturation_out = rsp_sat_ff;
   assign rsp_value_out      = rsp_val_ff;

endmodule

// ===== rtl/rgb2hsv_checker.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rgb2hsv_checker
   import rgb2hsv_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [HUE_W-1:0]  rsp_hue_out,
   input logic [SV_W-1:0]   rsp_saturation_out,
   input logic [SV_W-1:0]   rsp_value_out
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue_out)
         && $stable(rsp_saturation_out) && $stable(rsp_value_out))
      else $error("stalled result changed");

   // black pixel has no chroma
   a_black_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_out == '0 |-> rsp_saturation_out == '0 && rsp_hue_out == '0)
      else $error("black pixel with nonzero hue or saturation");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && req_stall |=> !req_stall)
      else $error("input stall held after result transfer");

endmodule

bind rgb_to_hsv_converter rgb2hsv_checker u_rgb2hsv_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_hue_out        (rsp_hue_out),
   .rsp_saturation_out (rsp_saturation_out),
   .rsp_value_out      (rsp_value_out)
);
